/* hw/rtl/atk_pkg.sv */
package atk_pkg;

  typedef struct packed {
    logic [7:0] chan_a;
    logic [7:0] chan_b;
    logic [7:0] chan_c;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] level;
    logic       frame_end;
  } pix_out_t;

  typedef logic signed [8:0] err_t;
  typedef logic signed [5:0] diff_t;

  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 13;
  localparam int unsigned THRESHOLD_W    = 8;
  localparam int unsigned LINE_WIDTH_W   = 12;
  localparam int unsigned FRAME_HEIGHT_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE   = 2'd3;

  localparam logic [THRESHOLD_W-1:0]    THRESHOLD_RST    = 8'd128;
  localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RST   = 12'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  localparam int unsigned MIN_DIM = 3;

  localparam logic [7:0] LEVEL_WHITE = 8'd255;
  localparam logic [7:0] LEVEL_BLACK = 8'd0;

  localparam int unsigned WSUM_W       = 15;
  localparam int unsigned DIV100_MUL_W = 13;
  localparam int unsigned PROD_W       = WSUM_W + DIV100_MUL_W;
  localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;

  localparam logic signed [9:0] SUM_MAX = 10'sd255;
  localparam logic signed [9:0] SUM_MIN = -10'sd256;
  localparam err_t ERR_MAX = 9'sd255;
  localparam err_t ERR_MIN = 9'sh100;

  typedef struct packed {
    logic              thr_en;
    logic              row_end;
    logic              frame_last;
    logic              x_lt2;
    logic              x_nonzero;
    logic              is_color;
    logic [WSUM_W-1:0] src;
  } s1_ctl_t;

  typedef struct packed {
    logic       thr_en;
    logic       row_end;
    logic       frame_last;
    logic       x_nonzero;
    logic [7:0] base;
  } dith_ctl_t;

  function automatic logic [WSUM_W-1:0] gray_wsum(pix_in_t p);
    logic [WSUM_W-1:0] sum;
    sum = ({7'b0, p.chan_a} * 15'd30) + ({7'b0, p.chan_b} * 15'd59)
        + ({7'b0, p.chan_c} * 15'd11);
    return sum;
  endfunction

  // floor(s/100) by reciprocal, exact for s below 25600
  function automatic logic [7:0] div100(logic [WSUM_W-1:0] s);
    logic [PROD_W-1:0] prod;
    prod = {{DIV100_MUL_W{1'b0}}, s} * {{WSUM_W{1'b0}}, DIV100_MUL};
    return prod[DIV100_SHIFT +: 8];
  endfunction

  function automatic err_t sat_err(logic signed [9:0] v);
    err_t r;
    if (v > SUM_MAX) begin
      r = ERR_MAX;
    end else if (v < SUM_MIN) begin
      r = ERR_MIN;
    end else begin
      r = v[8:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/atkinson_error_diffusion_dither.sv */
// path: an accepted pixel is registered in stage 1, then in stage 2, then in the output register,
//   which drives out_data_o
// throughput: one pixel per cycle while out_stall_i is low, bounded by the error loop through the
//   ahead registers and by one read and one write port on each line memory
// reset: configuration returns to defaults, position and pending errors clear, then both
//   line memories are swept to zero across all MAX_WIDTH entries (2048 by default), input stalled
module atkinson_error_diffusion_dither
  import atk_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pix_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pix_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WCW = (($clog2(MAX_WIDTH + 1) > LINE_WIDTH_W) ?
                                 $clog2(MAX_WIDTH + 1) : LINE_WIDTH_W) + 1;
  localparam int unsigned HCW = (($clog2(MAX_HEIGHT + 1) > FRAME_HEIGHT_W) ?
                                 $clog2(MAX_HEIGHT + 1) : FRAME_HEIGHT_W) + 1;

  logic [THRESHOLD_W-1:0]    thr_q;
  logic [LINE_WIDTH_W-1:0]   lw_q;
  logic [FRAME_HEIGHT_W-1:0] fh_q;
  logic                      color_q;

  logic          clr_q;
  logic [AW-1:0] clr_addr_q;

  logic [AW-1:0] col_q;
  logic [RW-1:0] row_q;

  logic [WCW-1:0] lw_ext, eff_w, col_ext;
  logic [HCW-1:0] fh_ext, eff_h, row_ext;
  logic           thr_en_c, row_end_c, frame_last_c;
  logic           in_acc;

  logic          s1_valid_q;
  s1_ctl_t       s1_ctl_q, s1_ctl_d;
  logic [AW-1:0] s1_x_q;
  logic          s1_adv;

  logic          s2_valid_q;
  dith_ctl_t     s2_ctl_q, s2_ctl_d;
  logic [AW-1:0] s2_x_q;
  logic          s2_go, s2_fire;

  logic     out_valid_q;
  pix_out_t out_data_q;

  err_t          nre_rd, sre_rd;
  logic [7:0]    level;
  logic          core_nre_we, core_sre_we;
  logic [AW-1:0] core_nre_waddr, core_sre_waddr;
  err_t          core_nre_wdata, core_sre_wdata;
  logic          nre_we, sre_we;
  logic [AW-1:0] nre_waddr, sre_waddr;
  err_t          nre_wdata, sre_wdata;

  // frame geometry
  always_comb begin
    lw_ext = WCW'(lw_q);
    fh_ext = HCW'(fh_q);
    if (lw_ext < WCW'(MIN_DIM)) begin
      eff_w = WCW'(MIN_DIM);
    end else if (lw_ext > WCW'(MAX_WIDTH)) begin
      eff_w = WCW'(MAX_WIDTH);
    end else begin
      eff_w = lw_ext;
    end
    if (fh_ext < HCW'(MIN_DIM)) begin
      eff_h = HCW'(MIN_DIM);
    end else if (fh_ext > HCW'(MAX_HEIGHT)) begin
      eff_h = HCW'(MAX_HEIGHT);
    end else begin
      eff_h = fh_ext;
    end
    col_ext      = WCW'(col_q);
    row_ext      = HCW'(row_q);
    thr_en_c     = (col_ext + WCW'(2) < eff_w) && (row_ext + HCW'(2) < eff_h);
    row_end_c    = (col_ext + WCW'(1) >= eff_w);
    frame_last_c = row_end_c && (row_ext + HCW'(1) >= eff_h);
  end

  // pipeline handshake
  assign s2_go      = !out_valid_q || !out_stall_i;
  assign s2_fire    = s2_valid_q && s2_go;
  assign s1_adv     = s1_valid_q && (!s2_valid_q || s2_go);
  assign in_stall_o = clr_q || (s1_valid_q && !s1_adv);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THRESHOLD_RST;
      lw_q    <= LINE_WIDTH_RST;
      fh_q    <= FRAME_HEIGHT_RST;
      color_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_THRESHOLD:    thr_q   <= cfg_data_i[THRESHOLD_W-1:0];
        REG_LINE_WIDTH:   lw_q    <= cfg_data_i[LINE_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: fh_q    <= cfg_data_i[FRAME_HEIGHT_W-1:0];
        REG_COLOR_MODE:   color_q <= cfg_data_i[0];
      endcase
    end
  end

  // zero sweep of the line memories
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == AW'(MAX_WIDTH - 1)) begin
        clr_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (row_end_c) begin
        col_q <= '0;
        if (frame_last_c) begin
          row_q <= '0;
        end else begin
          row_q <= row_q + RW'(1);
        end
      end else begin
        col_q <= col_q + AW'(1);
      end
    end
  end

  always_comb begin
    s1_ctl_d.thr_en     = thr_en_c;
    s1_ctl_d.row_end    = row_end_c;
    s1_ctl_d.frame_last = frame_last_c;
    s1_ctl_d.x_lt2      = (col_ext < WCW'(2));
    s1_ctl_d.x_nonzero  = (col_q != '0);
    s1_ctl_d.is_color   = color_q;
    s1_ctl_d.src        = color_q ? gray_wsum(in_data_i) : {7'b0, in_data_i.chan_a};
  end

  always_comb begin
    s2_ctl_d.thr_en     = s1_ctl_q.thr_en;
    s2_ctl_d.row_end    = s1_ctl_q.row_end;
    s2_ctl_d.frame_last = s1_ctl_q.frame_last;
    s2_ctl_d.x_nonzero  = s1_ctl_q.x_nonzero;
    if (s1_ctl_q.x_lt2) begin
      s2_ctl_d.base = LEVEL_WHITE;
    end else if (s1_ctl_q.is_color) begin
      s2_ctl_d.base = div100(s1_ctl_q.src);
    end else begin
      s2_ctl_d.base = s1_ctl_q.src[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
      end else if (s2_fire) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ctl_q <= s1_ctl_d;
      s1_x_q   <= col_q;
    end
    if (s1_adv) begin
      s2_ctl_q <= s2_ctl_d;
      s2_x_q   <= s1_x_q;
    end
    if (s2_fire) begin
      out_data_q.level     <= level;
      out_data_q.frame_end <= s2_ctl_q.frame_last;
    end
  end

  atk_diffuse #(
    .AW (AW)
  ) u_diffuse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s2_fire),
    .ctl_i       (s2_ctl_q),
    .x_i         (s2_x_q),
    .threshold_i (thr_q),
    .nre_i       (nre_rd),
    .sre_i       (sre_rd),
    .level_o     (level),
    .nre_we_o    (core_nre_we),
    .nre_waddr_o (core_nre_waddr),
    .nre_wdata_o (core_nre_wdata),
    .sre_we_o    (core_sre_we),
    .sre_waddr_o (core_sre_waddr),
    .sre_wdata_o (core_sre_wdata)
  );

  assign nre_we    = clr_q || core_nre_we;
  assign nre_waddr = clr_q ? clr_addr_q : core_nre_waddr;
  assign nre_wdata = clr_q ? '0 : core_nre_wdata;
  assign sre_we    = clr_q || core_sre_we;
  assign sre_waddr = clr_q ? clr_addr_q : core_sre_waddr;
  assign sre_wdata = clr_q ? '0 : core_sre_wdata;

  atk_err_ram #(
    .DEPTH (MAX_WIDTH)
  ) u_next_row_ram (
    .clk_i   (clk_i),
    .we_i    (nre_we),
    .waddr_i (nre_waddr),
    .wdata_i (nre_wdata),
    .re_i    (s1_adv),
    .raddr_i (s1_x_q),
    .rdata_o (nre_rd)
  );

  atk_err_ram #(
    .DEPTH (MAX_WIDTH)
  ) u_second_row_ram (
    .clk_i   (clk_i),
    .we_i    (sre_we),
    .waddr_i (sre_waddr),
    .wdata_i (sre_wdata),
    .re_i    (s1_adv),
    .raddr_i (s1_x_q),
    .rdata_o (sre_rd)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> (!s1_valid_q && !s2_valid_q && !out_valid_q))
    else $error("line memory sweep overlaps pixel traffic");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && core_nre_we) |-> (core_nre_waddr != s1_x_q))
    else $error("next-row write collides with read of the same entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && frame_last_c) |=> ((col_q == '0) && (row_q == '0)))
    else $error("position not wrapped after last pixel of frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_ctl_q.thr_en) |-> !s2_ctl_q.row_end)
    else $error("thresholded pixel at row end breaks error forwarding");

endmodule

/* hw/rtl/atk_err_ram.sv */
module atk_err_ram
  import atk_pkg::*;
#(
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  err_t                     wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output err_t                     rdata_o
);

  err_t mem_q [DEPTH];
  err_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/atk_diffuse.sv */
module atk_diffuse
  import atk_pkg::*;
#(
  parameter int unsigned AW = 11
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  dith_ctl_t              ctl_i,
  input  logic [AW-1:0]          x_i,
  input  logic [THRESHOLD_W-1:0] threshold_i,
  input  err_t                   nre_i,
  input  err_t                   sre_i,
  output logic [7:0]             level_o,
  output logic                   nre_we_o,
  output logic [AW-1:0]          nre_waddr_o,
  output err_t                   nre_wdata_o,
  output logic                   sre_we_o,
  output logic [AW-1:0]          sre_waddr_o,
  output err_t                   sre_wdata_o
);

  logic signed [6:0] a1_q, a1_d;
  diff_t             a2_q, a2_d;
  diff_t             ecarry_q;
  err_t              pend_q;
  logic [AW-1:0]     pend_addr_q;
  logic              pend_valid_q;

  err_t               sre_eff;
  err_t               nr;
  logic signed [10:0] val_sum;
  logic [7:0]         val;
  logic [7:0]         lvl;
  logic signed [8:0]  diff;
  logic [8:0]         mag;
  diff_t              e;

  always_comb begin
    // pending update of entry x from the previous pixel
    sre_eff = sat_err({sre_i[8], sre_i} + {{4{ecarry_q[5]}}, ecarry_q});
    val_sum = {3'b000, ctl_i.base} + {{4{a1_q[6]}}, a1_q} + {{2{nre_i[8]}}, nre_i};
    if (val_sum[10]) begin
      val = 8'd0;
    end else if (val_sum > 11'sd255) begin
      val = 8'd255;
    end else begin
      val = val_sum[7:0];
    end
    if (ctl_i.thr_en) begin
      lvl = (val >= threshold_i) ? LEVEL_WHITE : LEVEL_BLACK;
    end else begin
      lvl = val;
    end
    diff = {1'b0, val} - {1'b0, lvl};
    mag  = diff[8] ? (9'd0 - 9'(diff)) : 9'(diff);
    // share truncated toward zero
    if (!ctl_i.thr_en) begin
      e = '0;
    end else if (diff[8]) begin
      e = 6'd0 - {1'b0, mag[7:3]};
    end else begin
      e = {1'b0, mag[7:3]};
    end
    nr = sat_err({sre_eff[8], sre_eff} + {{4{e[5]}}, e});
    if (ctl_i.row_end) begin
      a1_d = '0;
      a2_d = '0;
    end else begin
      a1_d = {a2_q[5], a2_q} + {e[5], e};
      a2_d = e;
    end
  end

  assign level_o     = lvl;
  assign nre_we_o    = fire_i && pend_valid_q;
  assign nre_waddr_o = pend_addr_q;
  assign nre_wdata_o = sat_err({pend_q[8], pend_q}
                               + (ctl_i.x_nonzero ? {{4{e[5]}}, e} : 10'd0));
  assign sre_we_o    = fire_i;
  assign sre_waddr_o = x_i;
  assign sre_wdata_o = {{3{e[5]}}, e};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_q         <= '0;
      a2_q         <= '0;
      ecarry_q     <= '0;
      pend_valid_q <= 1'b0;
    end else if (fire_i) begin
      a1_q         <= a1_d;
      a2_q         <= a2_d;
      ecarry_q     <= e;
      pend_valid_q <= 1'b1;
    end
  end

  // entry x of the next-row store stays open for the following pixel
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      pend_q      <= nr;
      pend_addr_q <= x_i;
    end
  end

endmodule
